// ===== rtl/pqse_pkg.sv =====
// ----------------------------------------------------------------------------
// pqse_pkg
// Types and codes shared by the priority queue scan/extract block.
// ----------------------------------------------------------------------------
package pqse_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_EXTRACTED = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic       command;
    logic [7:0] item_byte;
    logic [7:0] rank;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic [7:0] out_rank;
    logic [7:0] held_count;
  } res_t;

  typedef struct packed {
    logic [7:0] item_byte;
    logic [7:0] rank;
  } entry_t;

endpackage

// ===== rtl/priority_queue_scan_extract.sv =====
// ----------------------------------------------------------------------------
// priority_queue_scan_extract
// Bounded priority queue in one memory; extract scans for the highest rank
// (oldest wins ties) and shifts the later entries down one place.
// Insert, overflow and empty: IDLE, then RESULT, then the output register.
// Extract: time grows with the held entries and falls as the winner sits later,
// set by the single read port used for the scan and then the shift pass.
// One command at a time; results wait in an output register.
// Reset clears the count and handshakes; entry memory is not cleared.
// ----------------------------------------------------------------------------
module priority_queue_scan_extract #(
  parameter int unsigned CAPACITY = pqse_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  pqse_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output pqse_pkg::res_t  res
);
  import pqse_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {IDLE, SCAN, SHIFT, RESULT} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic [IDX_W-1:0] best_idx;
  logic [7:0]       best_byte;
  logic [7:0]       best_rank;
  res_t             result;

  entry_t           mem [CAPACITY];
  entry_t           rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic             cmd_xfer;
  logic             full;
  logic             more;
  logic             take;
  logic [IDX_W-1:0] nb_idx;
  logic [7:0]       nb_byte;
  logic [7:0]       nb_rank;

  function automatic logic [7:0] hc(input logic [CNT_W-1:0] c);
    logic [CNT_W+7:0] w;
    w = {8'd0, c};
    return w[7:0];
  endfunction

  assign cmd_stall = (state != IDLE);
  assign cmd_xfer  = cmd_valid && !cmd_stall;
  assign full      = (count >= CAP_C);
  assign more      = (idx < count);

  // running maximum, strict compare keeps the oldest on ties
  assign take    = pend && ((pend_idx == '0) || (rd_data.rank > best_rank));
  assign nb_idx  = take ? pend_idx : best_idx;
  assign nb_byte = take ? rd_data.item_byte : best_byte;
  assign nb_rank = take ? rd_data.rank : best_rank;

  always_comb begin
    rd_en   = ((state == SCAN) || (state == SHIFT)) && more;
    rd_addr = idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = '{item_byte: cmd.item_byte, rank: cmd.rank};
    if (cmd_xfer && (cmd.command == CMD_INSERT) && !full) begin
      wr_en = 1'b1;
    end else if ((state == SHIFT) && pend) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx - IDX_W'(1);
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != RESULT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (cmd_xfer) begin
            result.out_byte <= '0;
            result.out_rank <= '0;
            if (cmd.command == CMD_INSERT) begin
              state <= RESULT;
              if (full) begin
                result.status     <= ST_OVERFLOW;
                result.held_count <= hc(count);
              end else begin
                count             <= count + CNT_W'(1);
                result.status     <= ST_INSERTED;
                result.held_count <= hc(count + CNT_W'(1));
              end
            end else if (count == '0) begin
              result.status     <= ST_EMPTY;
              result.held_count <= '0;
              state             <= RESULT;
            end else begin
              idx   <= '0;
              pend  <= 1'b0;
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          best_idx  <= nb_idx;
          best_byte <= nb_byte;
          best_rank <= nb_rank;
          pend      <= more;
          pend_idx  <= idx[IDX_W-1:0];
          if (more) begin
            idx <= idx + CNT_W'(1);
          end else if (pend) begin
            result.status   <= ST_EXTRACTED;
            result.out_byte <= nb_byte;
            result.out_rank <= nb_rank;
            idx             <= CNT_W'(nb_idx) + CNT_W'(1);
            state           <= SHIFT;
          end
        end
        SHIFT: begin
          pend     <= more;
          pend_idx <= idx[IDX_W-1:0];
          if (more) begin
            idx <= idx + CNT_W'(1);
          end else if (!pend) begin
            count             <= count - CNT_W'(1);
            result.held_count <= hc(count - CNT_W'(1));
            state             <= RESULT;
          end
        end
        RESULT: begin
          if (!res_valid || !res_stall) begin
            res       <= result;
            res_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("held count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd_xfer && (cmd.command == CMD_INSERT) && !full)
    |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == SCAN) && pend) |-> (CNT_W'(pend_idx) < count))
    else $error("scan read beyond held entries");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == ST_EMPTY))
    |-> ((res.held_count == 8'd0) && (res.out_byte == 8'd0)))
    else $error("empty result carries data");
`endif

endmodule

// ===== tb/priority_queue_scan_extract_tb.sv =====
// ----------------------------------------------------------------------------
// priority_queue_scan_extract_tb
// Self-checking bench for the priority queue scan/extract block. A directed
// opening covers empty extract, extreme bytes and ranks, and oldest-wins ties.
// Random bursts then fill to overflow, drain to empty, mix the two, and load
// heavy ties. A software copy of the queue predicts each transfer's result.
// Both handshakes idle at random, and the receiver holds off once for a long
// stretch. Every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module priority_queue_scan_extract_tb;
  import pqse_pkg::*;

  localparam int unsigned DEPTH      = CAPACITY_DEF;
  localparam int unsigned N_RANDOM   = 1550;
  localparam int unsigned QUIET_LO   = 700;
  localparam int unsigned QUIET_HI   = 900;
  localparam int unsigned HOLD_AT    = 300;
  localparam int unsigned HOLD_LEN   = 500;
  localparam int unsigned SETTLE_CYC = 2 * DEPTH + 40;

  typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_TIES} burst_kind_t;

  typedef struct packed {
    logic wait_drained;
    cmd_t c;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  stim_t       stim_q[$];
  res_t        expected_results[$];
  logic [7:0]  held_bytes[DEPTH];
  logic [7:0]  held_ranks[DEPTH];
  int unsigned held_total = 0;

  int unsigned cmds_accepted = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned status_tally[4] = '{default: 0};
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  priority_queue_scan_extract uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_queue_result(input cmd_t c);
    res_t r;
    int unsigned best;
    int unsigned i;
    r = '0;
    if (c.command == CMD_INSERT) begin
      if (held_total >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        held_bytes[held_total] = c.item_byte;
        held_ranks[held_total] = c.rank;
        held_total++;
        r.status = ST_INSERTED;
      end
    end else if (held_total == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      for (i = 1; i < held_total; i++) begin
        if (held_ranks[i] > held_ranks[best]) best = i;
      end
      r.status   = ST_EXTRACTED;
      r.out_byte = held_bytes[best];
      r.out_rank = held_ranks[best];
      held_total--;
      for (i = best; i < held_total; i++) begin
        held_bytes[i] = held_bytes[i + 1];
        held_ranks[i] = held_ranks[i + 1];
      end
    end
    r.held_count = 8'(held_total);
    expected_results.push_back(r);
  endfunction

  task automatic queue_cmd(input logic op, input logic [7:0] b, input logic [7:0] rk,
                           input logic drained);
    stim_t s;
    s.wait_drained = drained;
    s.c.command    = op;
    s.c.item_byte  = b;
    s.c.rank       = rk;
    stim_q.push_back(s);
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    logic take;
    logic idle;
    logic blocked;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      take = cmd_valid && !cmd_stall;
      if (take) begin
        predict_queue_result(cmd);
        cmds_accepted <= cmds_accepted + 1;
      end
      if (!cmd_valid || take) begin
        idle = !(cmds_accepted >= QUIET_LO && cmds_accepted < QUIET_HI) &&
               ($urandom_range(0, 99) < 9);
        blocked = stim_q.size() > 0 && stim_q[0].wait_drained &&
                  (take || cmds_accepted != results_seen);
        if (stim_q.size() > 0 && !idle && !blocked) begin
          cmd       <= stim_q[0].c;
          cmd_valid <= 1'b1;
          stim_q.pop_front();
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin : watch_proc
    res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d", res.status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (res.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, res.status);
            mismatches++;
          end
          if (res.out_byte !== want.out_byte) begin
            $error("out_byte expected %0d actual %0d", want.out_byte, res.out_byte);
            mismatches++;
          end
          if (res.out_rank !== want.out_rank) begin
            $error("out_rank expected %0d actual %0d", want.out_rank, res.out_rank);
            mismatches++;
          end
          if (res.held_count !== want.held_count) begin
            $error("held_count expected %0d actual %0d", want.held_count, res.held_count);
            mismatches++;
          end
          status_tally[want.status]++;
        end
        results_seen <= results_seen + 1;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        res_stall <= 1'b1;
      end else if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
        res_stall <= 1'b0;
      end else begin
        res_stall <= ($urandom_range(0, 99) < 9);
      end
    end
  end

  initial begin : run_proc
    int unsigned random_items;
    int unsigned burst;
    int unsigned len;
    int unsigned ins_pct;
    int unsigned k;
    burst_kind_t kind;
    logic op;
    logic [7:0] rk;

    // empty extract, extreme values, oldest-wins ties
    queue_cmd(CMD_EXTRACT, 8'h00, 8'h00, 1'b0);
    queue_cmd(CMD_INSERT,  8'h00, 8'h00, 1'b0);
    queue_cmd(CMD_INSERT,  8'hff, 8'hff, 1'b0);
    queue_cmd(CMD_INSERT,  8'ha5, 8'hff, 1'b0);
    queue_cmd(CMD_INSERT,  8'h5a, 8'h80, 1'b0);
    queue_cmd(CMD_INSERT,  8'h3c, 8'h00, 1'b0);
    queue_cmd(CMD_EXTRACT, 8'hff, 8'hff, 1'b0);
    queue_cmd(CMD_EXTRACT, 8'h00, 8'h00, 1'b0);
    queue_cmd(CMD_EXTRACT, 8'hff, 8'h00, 1'b0);
    queue_cmd(CMD_INSERT,  8'h12, 8'h00, 1'b0);
    queue_cmd(CMD_EXTRACT, 8'h00, 8'hff, 1'b0);
    queue_cmd(CMD_EXTRACT, 8'h00, 8'h00, 1'b0);
    queue_cmd(CMD_EXTRACT, 8'h00, 8'h00, 1'b0);
    queue_cmd(CMD_EXTRACT, 8'h00, 8'h00, 1'b0);

    random_items = 0;
    burst = 0;
    while (random_items < N_RANDOM) begin
      case (burst % 6)
        1: kind = BURST_FILL;
        4: kind = BURST_DRAIN;
        default: kind = ($urandom_range(0, 3) == 0) ? BURST_TIES : BURST_MIXED;
      endcase
      case (kind)
        BURST_FILL, BURST_DRAIN: len = $urandom_range(132, 140);
        BURST_TIES:              len = $urandom_range(20, 40);
        default:                 len = $urandom_range(20, 60);
      endcase
      ins_pct = $urandom_range(30, 70);
      for (k = 0; k < len; k++) begin
        rk = 8'($urandom_range(0, 255));
        case (kind)
          BURST_FILL:  op = CMD_INSERT;
          BURST_DRAIN: op = CMD_EXTRACT;
          BURST_TIES: begin
            op = ($urandom_range(0, 99) < 60) ? CMD_INSERT : CMD_EXTRACT;
            case ($urandom_range(0, 2))
              0: rk = 8'h00;
              1: rk = 8'h7f;
              default: rk = 8'hff;
            endcase
          end
          default: op = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_EXTRACT;
        endcase
        queue_cmd(op, 8'($urandom_range(0, 255)), rk, (k == 0) && (burst % 5 == 0));
        random_items++;
      end
      burst++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || cmd_valid) @(posedge clk);
    while (results_seen != cmds_accepted) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    $display("checked %0d transfers over %0d bursts: %0d inserted, %0d overflow,",
             results_seen, burst, status_tally[ST_INSERTED], status_tally[ST_OVERFLOW]);
    $display("  %0d extracted, %0d empty; %0d field mismatches",
             status_tally[ST_EXTRACTED], status_tally[ST_EMPTY], mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
